// ----- hdl/uer_pkg.sv -----
// shared types and constants of the ultrasonic echo ranger
`timescale 1ns / 1ps

package uer_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
   localparam logic [1:0] REG_TICKS_PER_CM  = 2'd1;
   localparam logic [1:0] REG_REAR_MAX_CM   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

   // register reset values
   localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
   localparam logic [7:0]  TICKS_PER_CM_RST  = 8'd58;
   localparam logic [9:0]  REAR_MAX_CM_RST   = 10'd200;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd35555;

   // command codes
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_FRONT = 2'd1;
   localparam logic [1:0] CMD_REAR  = 2'd2;
   localparam logic [1:0] CMD_BOTH  = 2'd3;

   localparam logic [9:0]  CM_MAX      = 10'd1023;
   localparam logic [7:0]  TRIG_MAX    = 8'd255;
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   // configuration as seen by the sequencer
   typedef struct packed {
      logic [7:0]  trigger_ticks;
      logic [7:0]  ticks_per_cm;
      logic [9:0]  rear_max_cm;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic       trig_front;
      logic       trig_rear;
      logic       done_res;
      logic [9:0] distance_cm;
      logic       sensor;
      logic       busy_res;
   } result_type;

endpackage

// ----- hdl/uer_seq.sv -----
// measurement sequencer: trigger, echo wait, pulse count and finish per tick
`timescale 1ns / 1ps

module uer_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [1:0]          command,
   input  logic                echo_front,
   input  logic                echo_rear,
   input  uer_pkg::cfg_type    cfg,
   output uer_pkg::result_type result
);
   import uer_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_TRIG_FRONT  = 3'd1,
      PH_WAIT_FRONT  = 3'd2,
      PH_PULSE_FRONT = 3'd3,
      PH_TRIG_REAR   = 3'd4,
      PH_WAIT_REAR   = 3'd5,
      PH_PULSE_REAR  = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  trig_cnt_ff, trig_cnt_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  sub_ff, sub_in;
   logic [9:0]  cm_ff, cm_in;
   logic        rear_pend_ff, rear_pend_in;
   logic [9:0]  last_dist_ff, last_dist_in;

   // next state and result for the tick at the input
   always_comb begin
      logic       rear;
      logic       pulse;
      logic       echo;
      logic       finish;
      logic [9:0] dist_cm;
      logic [8:0] sub_next;

      phase_in     = phase_ff;
      trig_cnt_in  = trig_cnt_ff;
      elapsed_in   = elapsed_ff;
      sub_in       = sub_ff;
      cm_in        = cm_ff;
      rear_pend_in = rear_pend_ff;
      last_dist_in = last_dist_ff;
      rear         = 1'b0;
      pulse        = 1'b0;
      echo         = 1'b0;
      finish       = 1'b0;
      dist_cm      = '0;
      sub_next     = '0;
      result       = '0;

      // command start while idle
      if (phase_ff == PH_IDLE && command != CMD_NONE) begin
         phase_in     = (command == CMD_REAR) ? PH_TRIG_REAR : PH_TRIG_FRONT;
         rear_pend_in = (command == CMD_BOTH);
         trig_cnt_in  = '0;
         elapsed_in   = '0;
         sub_in       = '0;
         cm_in        = '0;
      end

      case (phase_in)
         PH_TRIG_FRONT, PH_TRIG_REAR: begin
            rear = (phase_in == PH_TRIG_REAR);
            result.trig_rear  = rear;
            result.trig_front = !rear;
            if (trig_cnt_in < TRIG_MAX) begin
               trig_cnt_in = trig_cnt_in + 8'd1;
            end
            if (trig_cnt_in >= cfg.trigger_ticks) begin
               phase_in   = rear ? PH_WAIT_REAR : PH_WAIT_FRONT;
               elapsed_in = '0;
               sub_in     = '0;
               cm_in      = '0;
            end
         end
         PH_WAIT_FRONT, PH_WAIT_REAR, PH_PULSE_FRONT, PH_PULSE_REAR: begin
            pulse = (phase_in == PH_PULSE_FRONT) || (phase_in == PH_PULSE_REAR);
            rear  = (phase_in == PH_WAIT_REAR) || (phase_in == PH_PULSE_REAR);
            echo  = rear ? echo_rear : echo_front;
            if (pulse && !echo) begin
               // falling edge ends the pulse
               finish  = 1'b1;
               dist_cm = (rear && cm_in > cfg.rear_max_cm) ? 10'd0 : cm_in;
            end else begin
               if (!pulse && echo) begin
                  phase_in   = rear ? PH_PULSE_REAR : PH_PULSE_FRONT;
                  elapsed_in = '0;
                  sub_in     = '0;
                  cm_in      = '0;
                  pulse      = 1'b1;
               end
               // centimetre sub-counter
               if (pulse) begin
                  sub_next = {1'b0, sub_in} + 9'd1;
                  if (sub_next >= {1'b0, cfg.ticks_per_cm}) begin
                     sub_in = '0;
                     if (cm_in < CM_MAX) begin
                        cm_in = cm_in + 10'd1;
                     end
                  end else begin
                     sub_in = sub_next[7:0];
                  end
               end
               // wait or pulse timeout
               if (elapsed_in < ELAPSED_MAX) begin
                  elapsed_in = elapsed_in + 16'd1;
               end
               if (elapsed_in >= cfg.timeout_ticks) begin
                  finish  = 1'b1;
                  dist_cm = '0;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // measurement end, chain to rear when pending
      if (finish) begin
         result.done_res = 1'b1;
         result.sensor   = rear;
         last_dist_in    = dist_cm;
         elapsed_in      = '0;
         sub_in          = '0;
         cm_in           = '0;
         trig_cnt_in     = '0;
         phase_in        = (!rear && rear_pend_ff) ? PH_TRIG_REAR : PH_IDLE;
         rear_pend_in    = 1'b0;
      end

      result.distance_cm = last_dist_in;
      result.busy_res    = (phase_in != PH_IDLE);
   end

   // state registers, moved once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         trig_cnt_ff  <= '0;
         elapsed_ff   <= '0;
         sub_ff       <= '0;
         cm_ff        <= '0;
         rear_pend_ff <= 1'b0;
         last_dist_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         trig_cnt_ff  <= trig_cnt_in;
         elapsed_ff   <= elapsed_in;
         sub_ff       <= sub_in;
         cm_ff        <= cm_in;
         rear_pend_ff <= rear_pend_in;
         last_dist_ff <= last_dist_in;
      end
   end

endmodule

// ----- hdl/ultrasonic_echo_ranger_core.sv -----
// top level of the ultrasonic echo ranger: config registers and result register
//
//   port group | dir | handshake          | word
//   req_       | in  | req_valid/stall    | command, echo_front, echo_rear
//   rsp_       | out | rsp_valid/stall    | triggers, done, distance, sensor, busy
//   csr_       | in  | csr_write_en       | csr_index, csr_data
//
// one word in, one word out; a word is taken every cycle unless req_stall holds, its
// result shows in the next cycle from the result register.
// the sequencer state advances in the cycle a request word is accepted.
// req_stall rises only while the result register is full and rsp_stall holds.
// reset is synchronous and loads the default register values and idle state.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_echo_front,
   input  logic        req_echo_rear,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trig_front,
   output logic        rsp_trig_rear,
   output logic        rsp_done_res,
   output logic [9:0]  rsp_distance_cm,
   output logic        rsp_sensor,
   output logic        rsp_busy_res,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import uer_pkg::*;

   cfg_type    cfg_ff;
   result_type step_res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       req_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RST;
         cfg_ff.ticks_per_cm  <= TICKS_PER_CM_RST;
         cfg_ff.rear_max_cm   <= REAR_MAX_CM_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_data[7:0];
            REG_TICKS_PER_CM:  cfg_ff.ticks_per_cm  <= csr_data[7:0];
            REG_REAR_MAX_CM:   cfg_ff.rear_max_cm   <= csr_data[9:0];
            REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   // input side handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   uer_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_take),
      .command    (req_command),
      .echo_front (req_echo_front),
      .echo_rear  (req_echo_rear),
      .cfg        (cfg_ff),
      .result     (step_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trig_front  = rsp_ff.trig_front;
   assign rsp_trig_rear   = rsp_ff.trig_rear;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_distance_cm = rsp_ff.distance_cm;
   assign rsp_sensor      = rsp_ff.sensor;
   assign rsp_busy_res    = rsp_ff.busy_res;

   // checks
   a_one_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.trig_front && rsp_ff.trig_rear))
      else $error("both triggers driven");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.trig_front || rsp_ff.trig_rear) |-> rsp_ff.busy_res)
      else $error("trigger driven while not busy");

   a_rear_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res && rsp_ff.sensor
         |-> rsp_ff.distance_cm <= cfg_ff.rear_max_cm)
      else $error("rear distance above limit");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule

// ----- sim/tb_ultrasonic_echo_ranger_core.sv -----
// testbench of the ultrasonic echo ranger core: directed and random ranging against a tick predictor
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_core;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   typedef enum logic [2:0] {
      RNG_IDLE,
      RNG_TRIG_FRONT,
      RNG_WAIT_FRONT,
      RNG_PULSE_FRONT,
      RNG_TRIG_REAR,
      RNG_WAIT_REAR,
      RNG_PULSE_REAR
   } ranger_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_NONE;
   logic        req_echo_front = 1'b0;
   logic        req_echo_rear = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_trig_front;
   logic        rsp_trig_rear;
   logic        rsp_done_res;
   logic [9:0]  rsp_distance_cm;
   logic        rsp_sensor;
   logic        rsp_busy_res;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = REG_TRIGGER_TICKS;
   logic [15:0] csr_data = '0;

   // predictor copy of the registers and sequencer state
   logic [7:0]       cfg_trigger_ticks;
   logic [7:0]       cfg_ticks_per_cm;
   logic [9:0]       cfg_rear_max_cm;
   logic [15:0]      cfg_timeout_ticks;
   ranger_phase_type rg_phase;
   logic [7:0]       rg_trig_count;
   logic [15:0]      rg_elapsed;
   logic [7:0]       rg_subcount;
   logic [9:0]       rg_cm_count;
   logic             rg_rear_pending;
   logic [9:0]       rg_last_cm;

   result_type tick_reports[$];
   result_type due_word;
   int fail_count = 0;
   int word_count = 0;
   int ticks_taken = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   ultrasonic_echo_ranger_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_echo_front  (req_echo_front),
      .req_echo_rear   (req_echo_rear),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_trig_front  (rsp_trig_front),
      .rsp_trig_rear   (rsp_trig_rear),
      .rsp_done_res    (rsp_done_res),
      .rsp_distance_cm (rsp_distance_cm),
      .rsp_sensor      (rsp_sensor),
      .rsp_busy_res    (rsp_busy_res),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void zero_counters();
      rg_elapsed = '0;
      rg_subcount = '0;
      rg_cm_count = '0;
   endfunction

   function automatic void ranger_reset();
      cfg_trigger_ticks = TRIGGER_TICKS_RST;
      cfg_ticks_per_cm = TICKS_PER_CM_RST;
      cfg_rear_max_cm = REAR_MAX_CM_RST;
      cfg_timeout_ticks = TIMEOUT_TICKS_RST;
      rg_phase = RNG_IDLE;
      rg_trig_count = '0;
      zero_counters();
      rg_rear_pending = 1'b0;
      rg_last_cm = '0;
   endfunction

   // advance the sequencer by one tick and build the result word it gives
   function automatic result_type ranger_tick(input logic [1:0] cmd, input logic ef,
                                              input logic er);
      result_type r;
      logic       finish;
      logic       rear;
      logic       pulse;
      logic       echo;
      logic [9:0] range_cm;
      r = '0;
      finish = 1'b0;
      rear = 1'b0;
      range_cm = '0;

      // start a measurement only from idle
      if (rg_phase == RNG_IDLE && cmd != CMD_NONE) begin
         rg_phase = (cmd == CMD_REAR) ? RNG_TRIG_REAR : RNG_TRIG_FRONT;
         rg_rear_pending = (cmd == CMD_BOTH);
         rg_trig_count = '0;
         zero_counters();
      end

      case (rg_phase)
         RNG_TRIG_FRONT, RNG_TRIG_REAR: begin
            rear = (rg_phase == RNG_TRIG_REAR);
            if (rear) r.trig_rear = 1'b1;
            else r.trig_front = 1'b1;
            if (rg_trig_count < TRIG_MAX) rg_trig_count = rg_trig_count + 8'd1;
            if (rg_trig_count >= cfg_trigger_ticks) begin
               rg_phase = rear ? RNG_WAIT_REAR : RNG_WAIT_FRONT;
               zero_counters();
            end
         end
         RNG_WAIT_FRONT, RNG_WAIT_REAR, RNG_PULSE_FRONT, RNG_PULSE_REAR: begin
            pulse = (rg_phase == RNG_PULSE_FRONT || rg_phase == RNG_PULSE_REAR);
            rear = (rg_phase == RNG_WAIT_REAR || rg_phase == RNG_PULSE_REAR);
            echo = rear ? er : ef;
            if (!pulse && echo) begin
               rg_phase = rear ? RNG_PULSE_REAR : RNG_PULSE_FRONT;
               zero_counters();
               pulse = 1'b1;
            end else if (pulse && !echo) begin
               // falling edge ends the pulse
               finish = 1'b1;
               range_cm = rg_cm_count;
               if (rear && range_cm > cfg_rear_max_cm) range_cm = '0;
            end
            if (!finish) begin
               if (pulse) begin
                  rg_subcount = rg_subcount + 8'd1;
                  if (rg_subcount >= cfg_ticks_per_cm) begin
                     rg_subcount = '0;
                     if (rg_cm_count < CM_MAX) rg_cm_count = rg_cm_count + 10'd1;
                  end
               end
               if (rg_elapsed < ELAPSED_MAX) rg_elapsed = rg_elapsed + 16'd1;
               if (rg_elapsed >= cfg_timeout_ticks) begin
                  finish = 1'b1;
                  range_cm = '0;
               end
            end
         end
         default: rg_phase = RNG_IDLE;
      endcase

      // report and move on to the rear sensor of a double measurement
      if (finish) begin
         r.done_res = 1'b1;
         r.sensor = rear;
         rg_last_cm = range_cm;
         zero_counters();
         rg_trig_count = '0;
         rg_phase = (!rear && rg_rear_pending) ? RNG_TRIG_REAR : RNG_IDLE;
         rg_rear_pending = 1'b0;
      end

      r.distance_cm = rg_last_cm;
      r.busy_res = (rg_phase != RNG_IDLE);
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("result word %0d, %s: expected %0d, got %0d", word_count, field, want,
                     got);
      end
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         word_count++;
         if (tick_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("result word %0d arrived with none due", word_count);
         end else begin
            due_word = tick_reports.pop_front();
            check_field("trig_front", due_word.trig_front, rsp_trig_front);
            check_field("trig_rear", due_word.trig_rear, rsp_trig_rear);
            check_field("done_res", due_word.done_res, rsp_done_res);
            check_field("distance_cm", due_word.distance_cm, rsp_distance_cm);
            check_field("sensor", due_word.sensor, rsp_sensor);
            check_field("busy_res", due_word.busy_res, rsp_busy_res);
         end
      end
   end

   // send one tick word, holding it while stalled
   task automatic send_tick(input logic [1:0] cmd, input logic ef, input logic er);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_echo_front <= ef;
      req_echo_rear <= er;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_reports.push_back(ranger_tick(cmd, ef, er));
      ticks_taken++;
   endtask

   // hold off until every predicted word has come back
   task automatic await_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (tick_reports.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      await_reports();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_TRIGGER_TICKS: cfg_trigger_ticks = value[7:0];
         REG_TICKS_PER_CM:  cfg_ticks_per_cm = value[7:0];
         REG_REAR_MAX_CM:   cfg_rear_max_cm = value[9:0];
         REG_TIMEOUT_TICKS: cfg_timeout_ticks = value;
         default: ;
      endcase
   endtask

   // one measurement: echo rises after wait_len ticks and stays high pulse_len ticks,
   // the other echo line and the command carry noise while busy
   task automatic measure(input logic [1:0] cmd, input int wait_len, input int pulse_len);
      int   waited;
      int   pulsed;
      logic on_rear;
      logic was_rear;
      logic own;
      waited = 0;
      pulsed = 0;
      was_rear = 1'b0;
      send_tick(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)));
      while (rg_phase != RNG_IDLE) begin
         on_rear = (rg_phase == RNG_TRIG_REAR || rg_phase == RNG_WAIT_REAR ||
                    rg_phase == RNG_PULSE_REAR);
         if (on_rear != was_rear) begin
            waited = 0;
            pulsed = 0;
            was_rear = on_rear;
         end
         case (rg_phase)
            RNG_TRIG_FRONT, RNG_TRIG_REAR: own = 1'($urandom_range(1));
            RNG_WAIT_FRONT, RNG_WAIT_REAR: begin
               own = (waited >= wait_len);
               waited++;
               if (own) pulsed = 1;
            end
            default: begin
               own = (pulsed < pulse_len);
               pulsed++;
            end
         endcase
         if (on_rear) send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), own);
         else send_tick(2'($urandom_range(3)), own, 1'($urandom_range(1)));
      end
   endtask

   // random words, then random words until the block is idle again
   task automatic noise_burst();
      repeat ($urandom_range(1, 8))
         send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      while (rg_phase != RNG_IDLE)
         send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic test_reset_values();
      send_tick(CMD_NONE, 1'b1, 1'b1);
      measure(CMD_FRONT, 2, 120);
      measure(CMD_REAR, 1, 60);
   endtask

   task automatic test_commands();
      write_reg(REG_TRIGGER_TICKS, 16'd2);
      write_reg(REG_TICKS_PER_CM, 16'd3);
      write_reg(REG_REAR_MAX_CM, 16'd4);
      write_reg(REG_TIMEOUT_TICKS, 16'd40);
      send_tick(CMD_NONE, 1'b1, 1'b0);
      send_tick(CMD_NONE, 1'b0, 1'b1);
      measure(CMD_FRONT, 3, 7);
      measure(CMD_REAR, 0, 9);
      // rear reading above the limit reports zero
      measure(CMD_REAR, 2, 16);
      measure(CMD_BOTH, 1, 6);
   endtask

   task automatic test_timeouts();
      write_reg(REG_TIMEOUT_TICKS, 16'd12);
      measure(CMD_FRONT, 20, 3);
      measure(CMD_REAR, 2, 30);
      // front times out, then rear
      measure(CMD_BOTH, 20, 5);
      // pulse one short of the timeout, then exactly at it
      measure(CMD_FRONT, 0, 11);
      measure(CMD_FRONT, 0, 12);
   endtask

   task automatic test_zero_registers();
      write_reg(REG_TRIGGER_TICKS, 16'd0);
      write_reg(REG_TICKS_PER_CM, 16'd0);
      write_reg(REG_REAR_MAX_CM, 16'd5);
      write_reg(REG_TIMEOUT_TICKS, 16'd30);
      measure(CMD_BOTH, 1, 5);
      write_reg(REG_TIMEOUT_TICKS, 16'd0);
      measure(CMD_FRONT, 0, 3);
      measure(CMD_REAR, 3, 3);
   endtask

   task automatic test_extremes();
      write_reg(REG_TRIGGER_TICKS, 16'hFFFF);
      write_reg(REG_TICKS_PER_CM, 16'hFFFF);
      write_reg(REG_REAR_MAX_CM, 16'hFFFF);
      write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
      measure(CMD_FRONT, 2, 600);
      // distance saturates, and a rear limit at full scale still passes it
      write_reg(REG_TRIGGER_TICKS, 16'hFF01);
      write_reg(REG_TICKS_PER_CM, 16'hFF01);
      measure(CMD_REAR, 0, 1030);
   endtask

   task automatic pick_settings();
      logic [7:0]  trig_v;
      logic [7:0]  tpc_v;
      logic [9:0]  rmax_v;
      logic [15:0] tmo_v;
      trig_v = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
      tpc_v = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
      rmax_v = ($urandom_range(7) == 0) ? 10'd1023 : 10'($urandom_range(0, 12));
      tmo_v = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(4, 90));
      write_reg(REG_TRIGGER_TICKS, {8'($urandom_range(255)), trig_v});
      write_reg(REG_TICKS_PER_CM, {8'($urandom_range(255)), tpc_v});
      write_reg(REG_REAR_MAX_CM, {6'($urandom_range(63)), rmax_v});
      write_reg(REG_TIMEOUT_TICKS, tmo_v);
   endtask

   task automatic random_measurement();
      int span;
      int pulse_top;
      int wait_len;
      int pulse_len;
      span = (cfg_timeout_ticks > 300) ? 300 : int'(cfg_timeout_ticks) + 3;
      pulse_top = (cfg_ticks_per_cm > 50) ? 300 : 6 * int'(cfg_ticks_per_cm) + 1;
      wait_len = ($urandom_range(7) == 0) ? $urandom_range(0, span) : $urandom_range(0, 5);
      pulse_len = ($urandom_range(7) == 0) ? $urandom_range(1, span)
                                           : $urandom_range(1, pulse_top);
      if ($urandom_range(15) == 0) measure(CMD_NONE, wait_len, pulse_len);
      else measure(2'($urandom_range(CMD_BOTH, CMD_FRONT)), wait_len, pulse_len);
   endtask

   // random ranging under each idling pattern, two register settings per pattern
   task automatic test_random_ranging();
      int seg;
      int goal;
      for (seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 55; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 55; end
            default: begin send_gap_pct = 11; stall_pct = 11; end
         endcase
         pick_settings();
         goal = ticks_taken + 182;
         while (ticks_taken < goal) begin
            case ($urandom_range(15))
               0: noise_burst();
               1: await_reports();
               default: random_measurement();
            endcase
         end
      end
   endtask

   // reset, tests in turn, then drain and verdict
   initial begin
      ranger_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_commands();
      test_timeouts();
      test_zero_registers();
      test_extremes();
      test_random_ranging();
      await_reports();
      repeat (5) @(posedge clock);
      if (tick_reports.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
